// ----- sv/dxt1_dec_pkg.sv -----
// ----------------------------------------------------------------------------
// dxt1_dec_pkg
// shared types and constants of the dxt1 block decoder
// ----------------------------------------------------------------------------
package dxt1_dec_pkg;

   localparam int CFG_W          = 13;
   localparam int EP_W           = 16;
   localparam int IDX_W          = 32;
   localparam int CHAN_W         = 8;
   localparam int COORD_W        = 12;
   localparam int BLOCK_W        = 10;
   localparam int PIX_CNT_W      = 4;
   localparam int REQ_W          = 64;
   localparam int RSP_W          = 48;
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int BPR_MAX        = 1024;

   localparam logic [CFG_W-1:0]     SIZE_RESET = 13'd4096;
   localparam logic [PIX_CNT_W-1:0] PIX_LAST   = 4'd15;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CODE_EP0   = 2'd0,
      CODE_EP1   = 2'd1,
      CODE_MIX_A = 2'd2,
      CODE_MIX_B = 2'd3
   } code_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef rgb_type [3:0] pal_set_type;

endpackage

// ----- sv/dxt1_dec_palette.sv -----
// ----------------------------------------------------------------------------
// dxt1_dec_palette
// expands the two rgb565 endpoints and builds the four-entry palette
// ----------------------------------------------------------------------------
module dxt1_dec_palette
   import dxt1_dec_pkg::*;
(
   input  logic [EP_W-1:0] endpoint_zero,
   input  logic [EP_W-1:0] endpoint_one,
   output pal_set_type     palette
);

   localparam int SumW       = CHAN_W + 2;
   localparam int MulW       = 10;
   localparam int ProdW      = SumW + MulW;
   localparam int ThirdShift = 11;
   localparam logic [MulW-1:0] ThirdMul = 10'd683;

   // floor((2a + b) / 3) for sums below 768
   function automatic logic [CHAN_W-1:0] third(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
      logic [SumW-1:0]  sum;
      logic [ProdW-1:0] prod;
      sum  = (SumW'(a) << 1) + SumW'(b);
      prod = ProdW'(sum) * ProdW'(ThirdMul);
      return CHAN_W'(prod >> ThirdShift);
   endfunction

   function automatic logic [CHAN_W-1:0] half(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
      logic [CHAN_W:0] sum;
      sum = (CHAN_W+1)'(a) + (CHAN_W+1)'(b);
      return CHAN_W'(sum >> 1);
   endfunction

   rgb_type e0;
   rgb_type e1;
   logic    four_mode;

   always_comb begin
      e0.red    = {endpoint_zero[15:11], 3'b000};
      e0.green  = {endpoint_zero[10:5], 2'b00};
      e0.blue   = {endpoint_zero[4:0], 3'b000};
      e1.red    = {endpoint_one[15:11], 3'b000};
      e1.green  = {endpoint_one[10:5], 2'b00};
      e1.blue   = {endpoint_one[4:0], 3'b000};
      four_mode = endpoint_zero > endpoint_one;

      palette[0] = e0;
      palette[1] = e1;
      if (four_mode) begin
         palette[2].red   = third(e0.red, e1.red);
         palette[2].green = third(e0.green, e1.green);
         palette[2].blue  = third(e0.blue, e1.blue);
         palette[3].red   = third(e1.red, e0.red);
         palette[3].green = third(e1.green, e0.green);
         palette[3].blue  = third(e1.blue, e0.blue);
      end else begin
         palette[2].red   = half(e0.red, e1.red);
         palette[2].green = half(e0.green, e1.green);
         palette[2].blue  = half(e0.blue, e1.blue);
         palette[3]       = '0;
      end
   end

endmodule

// ----- sv/dxt1_block_decoder_core.sv -----
// ----------------------------------------------------------------------------
// dxt1_block_decoder_core
// decodes one dxt1 block per word into sixteen pixel words in raster order
// a block sits in the block stage, each pixel word in the output stage
// sixteen pixel words per block leave through the single pixel output port
// a new block is taken as its predecessor's last pixel word is registered
// reset: synchronous, clears counters and valids, size registers go to 4096
// ----------------------------------------------------------------------------
module dxt1_block_decoder_core
   import dxt1_dec_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // endpoint_zero, endpoint_one, index_word
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pixel_x, pixel_y, red, green, blue
   output logic [RSP_W-1:0] rsp_tdata,
   // inside_image
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int WidthBits  = $clog2(MAX_WIDTH + 1);
   localparam int HeightBits = $clog2(MAX_HEIGHT + 1);
   localparam int DimBits    = (WidthBits > HeightBits) ? WidthBits : HeightBits;
   localparam int SizeW      = (DimBits > CFG_W) ? DimBits : CFG_W;
   localparam int BprW       = SizeW + 1;

   // size registers
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;

   logic [SizeW-1:0] w_eff, h_eff;
   logic [BprW-1:0]  bpr_raw, bpr;

   // running block position
   logic [BLOCK_W-1:0] col_ff, col_in;
   logic [BLOCK_W-1:0] row_ff, row_in;
   logic [BLOCK_W:0]   col_p1;
   logic               row_wrap;

   // block stage
   logic                 blk_valid_ff, blk_valid_in;
   pal_set_type          blk_pal_ff, blk_pal_in;
   logic [IDX_W-1:0]     blk_idx_ff, blk_idx_in;
   logic [BLOCK_W-1:0]   blk_col_ff, blk_col_in;
   logic [BLOCK_W-1:0]   blk_row_ff, blk_row_in;
   logic [PIX_CNT_W-1:0] pix_cnt_ff, pix_cnt_in;

   // output stage
   logic               out_valid_ff, out_valid_in;
   logic [COORD_W-1:0] out_x_ff, out_x_in;
   logic [COORD_W-1:0] out_y_ff, out_y_in;
   logic               out_inside_ff, out_inside_in;
   rgb_type            out_rgb_ff, out_rgb_in;
   logic               out_last_ff, out_last_in;

   pal_set_type        new_pal;
   logic               out_ready, emit, last_emit, accept;
   logic [COORD_W-1:0] pix_x, pix_y;
   rgb_type            pix_rgb;

   dxt1_dec_palette u_palette (
      .endpoint_zero (req_tdata[15:0]),
      .endpoint_one  (req_tdata[31:16]),
      .palette       (new_pal)
   );

   always_comb begin
      if (width_ff == '0) begin
         w_eff = SizeW'(1);
      end else if (SizeW'(width_ff) > SizeW'(MAX_WIDTH)) begin
         w_eff = SizeW'(MAX_WIDTH);
      end else begin
         w_eff = SizeW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = SizeW'(1);
      end else if (SizeW'(height_ff) > SizeW'(MAX_HEIGHT)) begin
         h_eff = SizeW'(MAX_HEIGHT);
      end else begin
         h_eff = SizeW'(height_ff);
      end
      bpr_raw = (BprW'(w_eff) + BprW'(3)) >> 2;
      bpr     = (bpr_raw > BprW'(BPR_MAX)) ? BprW'(BPR_MAX) : bpr_raw;
   end

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign emit       = blk_valid_ff && out_ready;
   assign last_emit  = emit && (pix_cnt_ff == PIX_LAST);
   assign req_tready = !blk_valid_ff || last_emit;
   assign accept     = req_tvalid && req_tready;

   assign col_p1   = (BLOCK_W+1)'(col_ff) + (BLOCK_W+1)'(1);
   assign row_wrap = BprW'(col_p1) >= bpr;

   assign pix_x = {blk_col_ff, pix_cnt_ff[1:0]};
   assign pix_y = {blk_row_ff, pix_cnt_ff[3:2]};

   always_comb begin
      unique case (code_type'(blk_idx_ff[1:0]))
         CODE_EP0:   pix_rgb = blk_pal_ff[0];
         CODE_EP1:   pix_rgb = blk_pal_ff[1];
         CODE_MIX_A: pix_rgb = blk_pal_ff[2];
         CODE_MIX_B: pix_rgb = blk_pal_ff[3];
         default:    pix_rgb = blk_pal_ff[0];
      endcase
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default:          width_in  = width_ff;
         endcase
      end

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_wrap) begin
            col_in = '0;
            row_in = row_ff + BLOCK_W'(1);
         end else begin
            col_in = col_p1[BLOCK_W-1:0];
         end
      end

      blk_valid_in = blk_valid_ff;
      blk_pal_in   = blk_pal_ff;
      blk_idx_in   = blk_idx_ff;
      blk_col_in   = blk_col_ff;
      blk_row_in   = blk_row_ff;
      pix_cnt_in   = pix_cnt_ff;
      if (accept) begin
         blk_valid_in = 1'b1;
         blk_pal_in   = new_pal;
         blk_idx_in   = req_tdata[63:32];
         blk_col_in   = col_ff;
         blk_row_in   = row_ff;
         pix_cnt_in   = '0;
      end else if (emit) begin
         blk_valid_in = !last_emit;
         blk_idx_in   = blk_idx_ff >> 2;
         pix_cnt_in   = pix_cnt_ff + PIX_CNT_W'(1);
      end

      out_valid_in  = out_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_inside_in = out_inside_ff;
      out_rgb_in    = out_rgb_ff;
      out_last_in   = out_last_ff;
      if (out_ready) begin
         out_valid_in  = blk_valid_ff;
         out_x_in      = pix_x;
         out_y_in      = pix_y;
         out_inside_in = (SizeW'(pix_x) < w_eff) && (SizeW'(pix_y) < h_eff);
         out_rgb_in    = pix_rgb;
         out_last_in   = pix_cnt_ff == PIX_LAST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         blk_valid_ff <= 1'b0;
         pix_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         blk_valid_ff <= blk_valid_in;
         pix_cnt_ff   <= pix_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_pal_ff    <= blk_pal_in;
      blk_idx_ff    <= blk_idx_in;
      blk_col_ff    <= blk_col_in;
      blk_row_ff    <= blk_row_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_inside_ff <= out_inside_in;
      out_rgb_ff    <= out_rgb_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_rgb_ff.blue, out_rgb_ff.green, out_rgb_ff.red, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_inside_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- sv/dxt1_dec_checker.sv -----
// ----------------------------------------------------------------------------
// dxt1_dec_checker
// port-level checks of the dxt1 block decoder, bound to dxt1_block_decoder_core
// ----------------------------------------------------------------------------
module dxt1_dec_checker
   import dxt1_dec_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic [0:0]       rsp_tuser,
   input logic             rsp_tlast
);

   logic [PIX_CNT_W-1:0] pix_cnt_ff, pix_cnt_in;
   logic [1:0]           pending_ff, pending_in;
   logic                 req_take, rsp_take, blk_done;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;
   assign blk_done = rsp_take && rsp_tlast;

   always_comb begin
      pix_cnt_in = rsp_take ? pix_cnt_ff + PIX_CNT_W'(1) : pix_cnt_ff;
      pending_in = pending_ff + 2'(req_take) - 2'(blk_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_cnt_ff <= '0;
         pending_ff <= '0;
      end else begin
         pix_cnt_ff <= pix_cnt_in;
         pending_ff <= pending_in;
      end
   end

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled pixel word changed");

   // last flag on every sixteenth pixel only
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (pix_cnt_ff == PIX_LAST))
      else $error("last flag out of place");

   // raster order inside the block
   a_raster: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] == pix_cnt_ff[1:0]
         && rsp_tdata[13:12] == pix_cnt_ff[3:2])
      else $error("pixel order broken");

   // pixels only for taken blocks, at most two blocks in flight
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || pending_ff != 2'd0) && pending_ff != 2'd3)
      else $error("block count mismatch");

endmodule

bind dxt1_block_decoder_core dxt1_dec_checker u_dxt1_dec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- bench/dxt1_block_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// dxt1_block_decoder_core_tb
// self-checking bench for the dxt1 block decoder: blocks go in from a queue,
// a behavioral decoder predicts the sixteen pixel words of each block, and
// every pixel word that moves out is compared field by field with the oldest
// prediction, across several image sizes and random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dxt1_block_decoder_core_tb;
   import dxt1_dec_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] codes;
      logic [EP_W-1:0]  ep1;
      logic [EP_W-1:0]  ep0;
   } dxt1_word_type;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               in_image;
      rgb_type            color;
      logic               last_pix;
   } pixel_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0]       rsp_tuser;
   logic             rsp_tlast;
   logic             csr_we = 1'b0;
   logic [0:0]       csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   dxt1_word_type  blocks_to_send[$];
   pixel_type      pixels_due[$];
   dxt1_word_type  block_in_flight;
   logic [CFG_W-1:0]   width_reg = SIZE_RESET;
   logic [CFG_W-1:0]   height_reg = SIZE_RESET;
   logic [BLOCK_W-1:0] block_col = '0;
   logic [BLOCK_W-1:0] block_row = '0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          mismatches = 0;

   dxt1_block_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return 32'(v);
   endfunction

   function automatic rgb_type expand565(logic [EP_W-1:0] c);
      rgb_type e;
      e.red   = {c[15:11], 3'b000};
      e.green = {c[10:5], 2'b00};
      e.blue  = {c[4:0], 3'b000};
      return e;
   endfunction

   function automatic rgb_type blend(rgb_type a, rgb_type b, int unsigned wa,
                                     int unsigned wb, int unsigned div);
      rgb_type m;
      m.red   = CHAN_W'((wa * a.red + wb * b.red) / div);
      m.green = CHAN_W'((wa * a.green + wb * b.green) / div);
      m.blue  = CHAN_W'((wa * a.blue + wb * b.blue) / div);
      return m;
   endfunction

   // predicts the sixteen pixel words of one block and steps the block position
   function automatic void decode_block(dxt1_word_type blk);
      pal_set_type pal;
      pixel_type   pix;
      code_type    code;
      int unsigned w, h, bpr, x, y;
      w = eff_size(width_reg, MAX_WIDTH_DEF);
      h = eff_size(height_reg, MAX_HEIGHT_DEF);
      bpr = (w + 3) / 4;
      if (bpr > BPR_MAX) bpr = BPR_MAX;
      pal[CODE_EP0] = expand565(blk.ep0);
      pal[CODE_EP1] = expand565(blk.ep1);
      if (blk.ep0 > blk.ep1) begin
         pal[CODE_MIX_A] = blend(pal[CODE_EP0], pal[CODE_EP1], 2, 1, 3);
         pal[CODE_MIX_B] = blend(pal[CODE_EP0], pal[CODE_EP1], 1, 2, 3);
      end else begin
         pal[CODE_MIX_A] = blend(pal[CODE_EP0], pal[CODE_EP1], 1, 1, 2);
         pal[CODE_MIX_B] = '0;
      end
      for (int k = 0; k < 16; k++) begin
         code = code_type'(blk.codes[2*k +: 2]);
         x = block_col * 4 + k % 4;
         y = block_row * 4 + k / 4;
         pix.x = x[COORD_W-1:0];
         pix.y = y[COORD_W-1:0];
         pix.in_image = (x < w) && (y < h);
         pix.color = pal[code];
         pix.last_pix = (k == 15);
         pixels_due.push_back(pix);
      end
      if (block_col + 1 >= bpr) begin
         block_col = '0;
         block_row = block_row + 1'b1;
      end else begin
         block_col = block_col + 1'b1;
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // block driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) decode_block(block_in_flight);
         if (blocks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            block_in_flight = blocks_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= block_in_flight;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // pixel monitor
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixels_due.size() == 0) begin
               $display("%0t: unexpected pixel word, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pixels_due.pop_front();
               check_field("pixel_x", want.x, rsp_tdata[11:0]);
               check_field("pixel_y", want.y, rsp_tdata[23:12]);
               check_field("red", want.color.red, rsp_tdata[31:24]);
               check_field("green", want.color.green, rsp_tdata[39:32]);
               check_field("blue", want.color.blue, rsp_tdata[47:40]);
               check_field("inside_image", want.in_image, rsp_tuser);
               check_field("last_of_block", want.last_pix, rsp_tlast);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_block(logic [EP_W-1:0] ep0, logic [EP_W-1:0] ep1,
                             logic [IDX_W-1:0] codes);
      dxt1_word_type blk;
      blk.ep0 = ep0;
      blk.ep1 = ep1;
      blk.codes = codes;
      blocks_to_send.push_back(blk);
   endtask

   task automatic push_random_blocks(int n);
      logic [EP_W-1:0] ep0, ep1;
      repeat (n) begin
         ep0 = EP_W'($urandom_range(16'hFFFF));
         ep1 = EP_W'($urandom_range(16'hFFFF));
         case ($urandom_range(9))
            0: ep1 = ep0;
            1: ep1 = ep0 - 1'b1;
            2: ep1 = ep0 + 1'b1;
            default: ;
         endcase
         push_block(ep0, ep1, $urandom);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (blocks_to_send.size() != 0 || req_tvalid || pixels_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_register(csr_index_type idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      set_register(CSR_IMAGE_WIDTH, w);
      set_register(CSR_IMAGE_HEIGHT, h);
   endtask

   initial begin
      #3_000_000;
      $display("dxt1_block_decoder_core test failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 9;
      recv_idle_pct = 67;
      // reset size, four-colour, three-colour and black
      push_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
      push_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
      push_block(16'h1234, 16'h1234, 32'hFFFF_FFFF);
      push_block(16'h0000, 16'h0000, 32'hAAAA_AAAA);
      push_block(16'hFFFF, 16'hFFFF, 32'h5555_5555);
      push_block(16'hF800, 16'h07E0, 32'h1B1B_1B1B);
      push_block(16'h001F, 16'hF800, 32'hAAAA_AAAA);
      push_block(16'h8000, 16'h7FFF, 32'h0000_0000);
      push_block(16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
      push_block(16'h4321, 16'h4320, 32'h3939_C6C6);
      push_block(16'h4320, 16'h4321, 32'h3939_C6C6);
      push_block(16'hFFFF, 16'hFFFE, 32'hFFFF_FFFF);
      wait_drained();

      // zero size acts as one pixel
      set_size(13'd0, 13'd0);
      push_random_blocks(6);
      wait_drained();

      set_size(13'd13, 13'd9);
      push_random_blocks(20);
      wait_drained();
      push_random_blocks(20);
      wait_drained();

      send_idle_pct = 67;
      recv_idle_pct = 9;
      // oversized image clamps to the maximum
      set_size(13'd8191, 13'd8191);
      push_random_blocks(10);
      wait_drained();
      // narrowing leaves the column past the new row end
      set_size(13'd5, 13'd4097);
      push_random_blocks(12);
      wait_drained();
      repeat (5) begin
         set_size(CFG_W'($urandom_range(64, 1)), CFG_W'($urandom_range(40, 1)));
         push_random_blocks(14);
         wait_drained();
      end
      set_size(13'd1, 13'd4096);
      push_random_blocks(8);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // full size image, back to back
      set_size(13'd4096, 13'd4096);
      push_random_blocks(12);
      wait_drained();
      // one block per row
      set_size(13'd3, 13'd4000);
      push_random_blocks(10);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && pixels_due.size() == 0) begin
         $display("dxt1_block_decoder_core test passed");
      end else begin
         $display("dxt1_block_decoder_core test failed");
      end
      $finish;
   end

endmodule
